// File: design/ptsd_pkg.sv
package ptsd_pkg;

    localparam int CW      = 32;
    localparam int MW      = CW + 1;
    localparam int SQW     = 2 * MW;
    localparam int DDW     = SQW + 2;
    localparam int HW      = DDW / 2;
    localparam int PRW     = MW + DDW;
    localparam int PW      = PRW + 2;
    localparam int QW      = CW + 1;
    localparam int VW      = CW + 3;
    localparam int RW      = CW + 1;
    localparam int RTW     = CW + 2;
    localparam int SQ_LAT  = RTW + 1;
    localparam int GEO_LEN = 8 + QW;
    localparam int FLG_LEN = 4 + QW;
    localparam int LAT     = GEO_LEN + 3 + SQ_LAT;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord query_x;
        t_coord query_y;
        t_coord query_z;
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
    } t_in;

    typedef struct packed {
        logic [RW-1:0] distance;
        t_coord        near_x;
        t_coord        near_y;
        t_coord        near_z;
        logic          degenerate;
        logic          saturated;
    } t_out;

endpackage

// File: design/ptsd_div.sv
module ptsd_div (
    input  logic                      i_clk,
    input  logic [ptsd_pkg::PW-1:0]   i_num,
    input  logic [ptsd_pkg::DDW:0]    i_den,
    output logic [ptsd_pkg::QW-1:0]   o_quo
);
    import ptsd_pkg::*;

    // restoring division, one quotient bit per stage, most significant first
    logic [PW-1:0]  r_rem [QW-1];
    logic [DDW:0]   r_den [QW-1];
    logic [QW-1:0]  r_quo [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic [PW-1:0] w_rem;
        logic [DDW:0]  w_den;
        logic [QW-1:0] w_quo;
        logic [PW:0]   w_trial;

        if (j == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_den = r_den[j-1];
            assign w_quo = r_quo[j-1];
        end

        assign w_trial = {1'b0, w_rem} - {1'b0, (PW'(w_den) << K)};

        always_ff @(posedge i_clk) begin
            r_quo[j] <= w_trial[PW] ? w_quo : (w_quo | (QW'(1) << K));
        end

        if (j < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[j] <= w_trial[PW] ? w_rem : w_trial[PW-1:0];
                r_den[j] <= w_den;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// File: design/ptsd_sqrt.sv
module ptsd_sqrt (
    input  logic                      i_clk,
    input  logic [ptsd_pkg::DDW-1:0]  i_sq,
    output logic [ptsd_pkg::RW-1:0]   o_root
);
    import ptsd_pkg::*;

    // digit-by-digit root, one bit per stage, then round to nearest
    logic [DDW-1:0] r_rem  [RTW];
    logic [RTW-1:0] r_root [RTW];
    logic [RW-1:0]  r_out;

    for (genvar j = 0; j < RTW; j++) begin : g_stage
        localparam int B = RTW - 1 - j;
        logic [DDW-1:0] w_rem;
        logic [RTW-1:0] w_root;
        logic [DDW-1:0] w_trial;

        if (j == 0) begin : g_first
            assign w_rem  = i_sq;
            assign w_root = '0;
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
        end

        assign w_trial = (DDW'(w_root) << (B + 1)) | (DDW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (w_rem >= w_trial) begin
                r_rem[j]  <= w_rem - w_trial;
                r_root[j] <= w_root | (RTW'(1) << B);
            end else begin
                r_rem[j]  <= w_rem;
                r_root[j] <= w_root;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rem[RTW-1] > DDW'(r_root[RTW-1])) begin
            r_out <= RW'(r_root[RTW-1] + RTW'(1));
        end else begin
            r_out <= RW'(r_root[RTW-1]);
        end
    end

    assign o_root = r_out;

endmodule

// File: design/point_to_segment_distance.sv
// Throughput: one word per cycle, every cycle; busy is low except around reset.
// Most of the latency comes from the 33-stage restoring divider and the 35-stage square root.
// Synchronous active-low reset clears the valid line, sets busy and sets r_clamp to 1.
// The receiver cannot stall: each result is on o_res for exactly one cycle with o_strobe.
module point_to_segment_distance (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ptsd_pkg::t_in     i_cmd,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    output logic              o_strobe,
    output ptsd_pkg::t_out    o_res
);
    import ptsd_pkg::*;

    typedef struct packed {
        t_coord [2:0] q;
        t_coord [2:0] s;
        logic   [2:0] dsgn;
        logic         clamp;
    } t_geo;

    typedef struct packed {
        logic degen;
        logic dneg;
    } t_flg;

    typedef struct packed {
        t_coord [2:0] nr;
        logic         degen;
        logic         sat;
    } t_fin;

    logic           r_clamp;
    logic           r_busy;
    logic [LAT-1:0] r_vld;
    logic           w_acc;

    t_coord in_q [3];
    t_coord in_s [3];
    t_coord in_e [3];

    assign in_q[0] = i_cmd.query_x;
    assign in_q[1] = i_cmd.query_y;
    assign in_q[2] = i_cmd.query_z;
    assign in_s[0] = i_cmd.start_x;
    assign in_s[1] = i_cmd.start_y;
    assign in_s[2] = i_cmd.start_z;
    assign in_e[0] = i_cmd.end_x;
    assign in_e[1] = i_cmd.end_y;
    assign in_e[2] = i_cmd.end_z;

    assign w_acc       = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= 1'b1;
            r_busy  <= 1'b1;
            r_vld   <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[LAT-2:0], w_acc};
            if (i_cfg_valid && o_cfg_ready) begin
                r_clamp <= i_cfg_data;
            end
        end
    end

    // stage 1: differences
    logic signed [CW:0] n1_d [3];
    logic signed [CW:0] n1_w [3];
    logic signed [CW:0] r1_d [3];
    logic signed [CW:0] r1_w [3];
    t_geo               n_geo;
    t_geo               r_geo [GEO_LEN];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_d[i]      = {in_e[i][CW-1], in_e[i]} - {in_s[i][CW-1], in_s[i]};
            n1_w[i]      = {in_q[i][CW-1], in_q[i]} - {in_s[i][CW-1], in_s[i]};
            n_geo.q[i]    = in_q[i];
            n_geo.s[i]    = in_s[i];
            n_geo.dsgn[i] = n1_d[i][CW];
        end
        n_geo.clamp = r_clamp;
    end

    always_ff @(posedge i_clk) begin
        r1_d     <= n1_d;
        r1_w     <= n1_w;
        r_geo[0] <= n_geo;
        for (int k = 1; k < GEO_LEN; k++) begin
            r_geo[k] <= r_geo[k-1];
        end
    end

    // stage 2: magnitudes and products
    logic [MW-1:0]  n2_a [3];
    logic [MW-1:0]  n2_b [3];
    logic [SQW-1:0] r2_dsq [3];
    logic [SQW-1:0] r2_dw [3];
    logic [2:0]     r2_neg;
    logic [MW-1:0]  r2_a [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_a[i] = r1_d[i][CW] ? MW'(-r1_d[i]) : MW'(r1_d[i]);
            n2_b[i] = r1_w[i][CW] ? MW'(-r1_w[i]) : MW'(r1_w[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_dsq[i] <= n2_a[i] * n2_a[i];
            r2_dw[i]  <= n2_a[i] * n2_b[i];
            r2_neg[i] <= r1_d[i][CW] ^ r1_w[i][CW];
        end
        r2_a <= n2_a;
    end

    // stage 3: sums
    logic [DDW-1:0] n3_pos;
    logic [DDW-1:0] n3_neg;
    logic [DDW-1:0] r3_dd;
    logic [DDW-1:0] r3_pos;
    logic [DDW-1:0] r3_neg;
    logic [MW-1:0]  r3_a [3];

    always_comb begin
        n3_pos = '0;
        n3_neg = '0;
        for (int i = 0; i < 3; i++) begin
            if (r2_neg[i]) begin
                n3_neg = n3_neg + DDW'(r2_dw[i]);
            end else begin
                n3_pos = n3_pos + DDW'(r2_dw[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_dd  <= DDW'(r2_dsq[0]) + DDW'(r2_dsq[1]) + DDW'(r2_dsq[2]);
        r3_pos <= n3_pos;
        r3_neg <= n3_neg;
        r3_a   <= r2_a;
    end

    // stage 4: signed dot product
    logic signed [DDW:0] r4_dot;
    logic [DDW-1:0]      r4_dd;
    logic                r4_degen;
    logic [MW-1:0]       r4_a [3];

    always_ff @(posedge i_clk) begin
        r4_dot   <= $signed({1'b0, r3_pos}) - $signed({1'b0, r3_neg});
        r4_dd    <= r3_dd;
        r4_degen <= (r3_dd == '0);
        r4_a     <= r3_a;
    end

    // stage 5: magnitude and clamp
    logic [DDW-1:0] n5_mag;
    logic [DDW-1:0] n5_dotm;
    logic           n5_dneg;
    logic [DDW-1:0] r5_dotm;
    logic [DDW-1:0] r5_dd;
    logic [MW-1:0]  r5_a [3];
    t_flg           r_flg [FLG_LEN];

    always_comb begin
        n5_mag = r4_dot[DDW] ? DDW'(-r4_dot) : DDW'(r4_dot);
        if (r_geo[3].clamp) begin
            n5_dneg = 1'b0;
            if (r4_dot[DDW]) begin
                n5_dotm = '0;
            end else if (n5_mag > r4_dd) begin
                n5_dotm = r4_dd;
            end else begin
                n5_dotm = n5_mag;
            end
        end else begin
            n5_dotm = n5_mag;
            n5_dneg = r4_dot[DDW];
        end
    end

    always_ff @(posedge i_clk) begin
        r5_dotm  <= n5_dotm;
        r5_dd    <= r4_dd;
        r5_a     <= r4_a;
        r_flg[0] <= '{degen: r4_degen, dneg: n5_dneg};
        for (int k = 1; k < FLG_LEN; k++) begin
            r_flg[k] <= r_flg[k-1];
        end
    end

    // stages 6 to 8: split product, numerator 2*|d|*dotm + dd, denominator 2*dd
    logic [MW+HW-1:0]     r6_plo [3];
    logic [MW+DDW-HW-1:0] r6_phi [3];
    logic [DDW-1:0]       r6_dd;
    logic [PRW-1:0]       r7_prod [3];
    logic [DDW-1:0]       r7_dd;
    logic [PW-1:0]        r8_num [3];
    logic [DDW:0]         r8_den;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r6_plo[i]  <= r5_a[i] * r5_dotm[HW-1:0];
            r6_phi[i]  <= r5_a[i] * r5_dotm[DDW-1:HW];
            r7_prod[i] <= PRW'(r6_plo[i]) + (PRW'(r6_phi[i]) << HW);
            r8_num[i]  <= PW'({r7_prod[i], 1'b0}) + PW'(r7_dd);
        end
        r6_dd  <= r5_dd;
        r7_dd  <= r6_dd;
        r8_den <= {r7_dd, 1'b0};
    end

    logic [QW-1:0] w_quo [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        ptsd_div u_div (
            .i_clk (i_clk),
            .i_num (r8_num[i]),
            .i_den (r8_den),
            .o_quo (w_quo[i])
        );
    end

    // stage A: closest point with saturation
    t_geo                nA_geo;
    t_flg                nA_flg;
    logic signed [VW-1:0] nA_v [3];
    logic [VW-CW:0]       nA_top [3];
    t_coord               nA_nr [3];
    logic                 nA_sat;
    t_coord               rA_nr [3];
    t_coord               rA_q [3];
    logic                 rA_degen;
    logic                 rA_sat;

    always_comb begin
        nA_geo = r_geo[GEO_LEN-1];
        nA_flg = r_flg[FLG_LEN-1];
        nA_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (nA_geo.dsgn[i] ^ nA_flg.dneg) begin
                nA_v[i] = VW'(nA_geo.s[i]) - $signed(VW'(w_quo[i]));
            end else begin
                nA_v[i] = VW'(nA_geo.s[i]) + $signed(VW'(w_quo[i]));
            end
            nA_top[i] = nA_v[i][VW-1:CW-1];
            if (nA_flg.degen) begin
                nA_nr[i] = nA_geo.s[i];
            end else if ((&nA_top[i]) || !(|nA_top[i])) begin
                nA_nr[i] = nA_v[i][CW-1:0];
            end else if (nA_v[i][VW-1]) begin
                nA_nr[i] = {1'b1, {(CW-1){1'b0}}};
                nA_sat   = 1'b1;
            end else begin
                nA_nr[i] = {1'b0, {(CW-1){1'b1}}};
                nA_sat   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            rA_nr[i] <= nA_nr[i];
            rA_q[i]  <= nA_geo.q[i];
        end
        rA_degen <= nA_flg.degen;
        rA_sat   <= nA_sat;
    end

    // stages B and C: squared distance
    logic signed [CW:0] nB_diff [3];
    logic [MW-1:0]      nB_mag [3];
    logic [SQW-1:0]     rB_sq [3];
    t_fin               rB_fin;
    logic [DDW-1:0]     rC_sum;
    t_fin               rC_fin;
    t_fin               r_fin [SQ_LAT];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nB_diff[i] = {rA_q[i][CW-1], rA_q[i]} - {rA_nr[i][CW-1], rA_nr[i]};
            nB_mag[i]  = nB_diff[i][CW] ? MW'(-nB_diff[i]) : MW'(nB_diff[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            rB_sq[i]     <= nB_mag[i] * nB_mag[i];
            rB_fin.nr[i] <= rA_nr[i];
        end
        rB_fin.degen <= rA_degen;
        rB_fin.sat   <= rA_sat;
        rC_sum   <= DDW'(rB_sq[0]) + DDW'(rB_sq[1]) + DDW'(rB_sq[2]);
        rC_fin   <= rB_fin;
        r_fin[0] <= rC_fin;
        for (int k = 1; k < SQ_LAT; k++) begin
            r_fin[k] <= r_fin[k-1];
        end
    end

    logic [RW-1:0] w_root;

    ptsd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_sq   (rC_sum),
        .o_root (w_root)
    );

    assign o_strobe         = r_vld[LAT-1];
    assign o_res.distance   = w_root;
    assign o_res.near_x     = r_fin[SQ_LAT-1].nr[0];
    assign o_res.near_y     = r_fin[SQ_LAT-1].nr[1];
    assign o_res.near_z     = r_fin[SQ_LAT-1].nr[2];
    assign o_res.degenerate = r_fin[SQ_LAT-1].degen;
    assign o_res.saturated  = r_fin[SQ_LAT-1].sat;

endmodule

// File: design/ptsd_check.sv
module ptsd_check (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input ptsd_pkg::t_in   i_cmd,
    input logic            o_strobe,
    input ptsd_pkg::t_out  o_res
);
    import ptsd_pkg::*;

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without matching word");

    a_degen_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.degenerate) |->
            (!o_res.saturated && o_res.near_x == $past(i_cmd.start_x, LAT)
             && o_res.near_y == $past(i_cmd.start_y, LAT)
             && o_res.near_z == $past(i_cmd.start_z, LAT)))
        else $error("degenerate result is not the first end point");

endmodule

bind point_to_segment_distance ptsd_check u_ptsd_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);
